/* sv/biq_pkg.sv */
package biq_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_FRAC_BITS = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FORM_SELECT = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D_MAC0,
    ST_D_MAC1,
    ST_D_MAC2,
    ST_D_MAC3,
    ST_D_MAC4,
    ST_D_DRAIN,
    ST_T_MUL0,
    ST_T_WAIT0,
    ST_T_MUL1,
    ST_T_MUL2,
    ST_T_WAIT1,
    ST_T_MUL3,
    ST_T_MUL4,
    ST_T_WAIT2,
    ST_OUT
  } biq_state_e;

  typedef enum logic [1:0] {
    ACC_ZERO,
    ACC_H1,
    ACC_H2
  } biq_acc_src_e;

  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } biq_coef_e;

  typedef enum logic [2:0] {
    OPND_X,
    OPND_H1,
    OPND_H2,
    OPND_YO1,
    OPND_YO2,
    OPND_Y
  } biq_opnd_e;

  typedef struct packed {
    logic         take_in;
    logic         acc_load;
    biq_acc_src_e acc_src;
    logic         mul_en;
    logic         mul_sub;
    biq_coef_e    coef_sel;
    biq_opnd_e    opnd_sel;
    logic         y_capture;
    logic         n1_capture;
    logic         commit;
  } biq_cmd_t;

  typedef struct packed {
    logic form_tdf2;
  } biq_status_t;

endpackage

/* sv/biq_datapath.sv */
module biq_datapath #(
  parameter int SAMPLE_WIDTH   = biq_pkg::SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [biq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [COEF_FRAC_BITS+2:0]         cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  input  logic                              clear_history_i,
  input  biq_pkg::biq_cmd_t                 cmd_i,
  output biq_pkg::biq_status_t              status_o,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out_o,
  output logic                              saturated_o
);
  import biq_pkg::*;

  localparam int COEF_W = COEF_FRAC_BITS + 3;
  localparam int ACC_W  = SAMPLE_WIDTH + COEF_FRAC_BITS + 4;
  localparam int PROD_W = COEF_W + ACC_W;
  // sums wrap at 64 bits; below that the headroom means they never wrap
  localparam int SUM_W  = (PROD_W + 3 > 64) ? 64 : PROD_W + 3;

  localparam logic signed [COEF_W-1:0] B0_RESET = {3'b001, {COEF_FRAC_BITS{1'b0}}};
  localparam logic signed [SUM_W-1:0]  HALF =
    {{(SUM_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [SUM_W-1:0]  Y_HI =
    {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  Y_LO = ~Y_HI;
  localparam logic signed [SUM_W-1:0]  A_HI =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  A_LO = ~A_HI;

  logic signed [COEF_W-1:0]       b0_q, b1_q, b2_q, a1_q, a2_q;
  logic                           form_q;
  logic signed [ACC_W-1:0]        h1_q, h2_q, n1_q;
  logic signed [SAMPLE_WIDTH-1:0] yo1_q, yo2_q, x_q, y_q, sample_out_q;
  logic                           ysat_q, saturated_q;
  logic signed [PROD_W-1:0]       prod_q, prod_d;
  logic                           prod_vld_q, prod_sub_q;
  logic signed [SUM_W-1:0]        acc_q, acc_d, acc_load_val;
  logic signed [COEF_W-1:0]       coef_mux;
  logic signed [ACC_W-1:0]        opnd_mux;
  logic signed [SUM_W-1:0]        rnd, rsh;
  logic                           y_clip_hi, y_clip_lo;
  logic signed [SAMPLE_WIDTH-1:0] y_val;
  logic signed [ACC_W-1:0]        acc_sat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q   <= B0_RESET;
      b1_q   <= '0;
      b2_q   <= '0;
      a1_q   <= '0;
      a2_q   <= '0;
      form_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COEF_B0:     b0_q   <= cfg_data_i;
        CFG_COEF_B1:     b1_q   <= cfg_data_i;
        CFG_COEF_B2:     b2_q   <= cfg_data_i;
        CFG_COEF_A1:     a1_q   <= cfg_data_i;
        CFG_COEF_A2:     a2_q   <= cfg_data_i;
        CFG_FORM_SELECT: form_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign status_o.form_tdf2 = form_q;

  // shared multiplier operand selection
  always_comb begin
    case (cmd_i.coef_sel)
      COEF_B0: coef_mux = b0_q;
      COEF_B1: coef_mux = b1_q;
      COEF_B2: coef_mux = b2_q;
      COEF_A1: coef_mux = a1_q;
      COEF_A2: coef_mux = a2_q;
      default: coef_mux = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.opnd_sel)
      OPND_X:   opnd_mux = ACC_W'(x_q);
      OPND_H1:  opnd_mux = h1_q;
      OPND_H2:  opnd_mux = h2_q;
      OPND_YO1: opnd_mux = ACC_W'(yo1_q);
      OPND_YO2: opnd_mux = ACC_W'(yo2_q);
      OPND_Y:   opnd_mux = ACC_W'(y_q);
      default:  opnd_mux = '0;
    endcase
  end

  assign prod_d = coef_mux * opnd_mux;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_sub_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
      prod_sub_q <= cmd_i.mul_sub;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // accumulator: load a start value, or add or subtract the product from the cycle before
  always_comb begin
    case (cmd_i.acc_src)
      ACC_ZERO: acc_load_val = '0;
      ACC_H1:   acc_load_val = SUM_W'(h1_q);
      ACC_H2:   acc_load_val = SUM_W'(h2_q);
      default:  acc_load_val = '0;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_load) begin
      acc_d = acc_load_val;
    end else if (prod_vld_q) begin
      acc_d = prod_sub_q ? acc_q - SUM_W'(prod_q) : acc_q + SUM_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // round half up, then saturate to the sample width
  assign rnd       = acc_q + HALF;
  assign rsh       = rnd >>> COEF_FRAC_BITS;
  assign y_clip_hi = rsh > Y_HI;
  assign y_clip_lo = rsh < Y_LO;
  assign y_val     = y_clip_hi ? Y_HI[SAMPLE_WIDTH-1:0] :
                     y_clip_lo ? Y_LO[SAMPLE_WIDTH-1:0] : rsh[SAMPLE_WIDTH-1:0];

  // saturate the accumulator to history width
  assign acc_sat = (acc_q > A_HI) ? A_HI[ACC_W-1:0] :
                   (acc_q < A_LO) ? A_LO[ACC_W-1:0] : acc_q[ACC_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.y_capture) begin
      y_q    <= y_val;
      ysat_q <= y_clip_hi | y_clip_lo;
    end
    if (cmd_i.n1_capture) begin
      n1_q <= acc_sat;
    end
    if (cmd_i.commit) begin
      sample_out_q <= form_q ? y_q : y_val;
      saturated_q  <= form_q ? ysat_q : (y_clip_hi | y_clip_lo);
    end
  end

  // filter history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_q  <= '0;
      h2_q  <= '0;
      yo1_q <= '0;
      yo2_q <= '0;
    end else if (cmd_i.take_in && clear_history_i) begin
      h1_q  <= '0;
      h2_q  <= '0;
      yo1_q <= '0;
      yo2_q <= '0;
    end else if (cmd_i.commit) begin
      if (!form_q) begin
        h2_q  <= h1_q;
        h1_q  <= ACC_W'(x_q);
        yo2_q <= yo1_q;
        yo1_q <= y_val;
      end else begin
        h1_q <= n1_q;
        h2_q <= acc_sat;
      end
    end
  end

  assign sample_out_o = sample_out_q;
  assign saturated_o  = saturated_q;

endmodule

/* sv/biq_ctrl.sv */
module biq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  biq_pkg::biq_status_t status_i,
  output biq_pkg::biq_cmd_t    cmd_o
);
  import biq_pkg::*;

  biq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = status_i.form_tdf2 ? ST_T_MUL0 : ST_D_MAC0;
      ST_D_MAC0:  state_d = ST_D_MAC1;
      ST_D_MAC1:  state_d = ST_D_MAC2;
      ST_D_MAC2:  state_d = ST_D_MAC3;
      ST_D_MAC3:  state_d = ST_D_MAC4;
      ST_D_MAC4:  state_d = ST_D_DRAIN;
      ST_D_DRAIN: state_d = ST_OUT;
      ST_T_MUL0:  state_d = ST_T_WAIT0;
      ST_T_WAIT0: state_d = ST_T_MUL1;
      ST_T_MUL1:  state_d = ST_T_MUL2;
      ST_T_MUL2:  state_d = ST_T_WAIT1;
      ST_T_WAIT1: state_d = ST_T_MUL3;
      ST_T_MUL3:  state_d = ST_T_MUL4;
      ST_T_MUL4:  state_d = ST_T_WAIT2;
      ST_T_WAIT2: state_d = ST_OUT;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.take_in = in_valid_i;
      end
      ST_D_MAC0: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.acc_src  = ACC_ZERO;
        cmd_o.mul_en   = 1'b1;
        cmd_o.coef_sel = COEF_B0;
        cmd_o.opnd_sel = OPND_X;
      end
      ST_D_MAC1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.coef_sel = COEF_B1;
        cmd_o.opnd_sel = OPND_H1;
      end
      ST_D_MAC2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.coef_sel = COEF_B2;
        cmd_o.opnd_sel = OPND_H2;
      end
      ST_D_MAC3: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sub  = 1'b1;
        cmd_o.coef_sel = COEF_A1;
        cmd_o.opnd_sel = OPND_YO1;
      end
      ST_D_MAC4: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sub  = 1'b1;
        cmd_o.coef_sel = COEF_A2;
        cmd_o.opnd_sel = OPND_YO2;
      end
      ST_T_MUL0: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.acc_src  = ACC_H1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.coef_sel = COEF_B0;
        cmd_o.opnd_sel = OPND_X;
      end
      ST_T_MUL1: begin
        cmd_o.y_capture = 1'b1;
        cmd_o.acc_load  = 1'b1;
        cmd_o.acc_src   = ACC_H2;
        cmd_o.mul_en    = 1'b1;
        cmd_o.coef_sel  = COEF_B1;
        cmd_o.opnd_sel  = OPND_X;
      end
      ST_T_MUL2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sub  = 1'b1;
        cmd_o.coef_sel = COEF_A1;
        cmd_o.opnd_sel = OPND_Y;
      end
      ST_T_MUL3: begin
        cmd_o.n1_capture = 1'b1;
        cmd_o.acc_load   = 1'b1;
        cmd_o.acc_src    = ACC_ZERO;
        cmd_o.mul_en     = 1'b1;
        cmd_o.coef_sel   = COEF_B2;
        cmd_o.opnd_sel   = OPND_X;
      end
      ST_T_MUL4: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sub  = 1'b1;
        cmd_o.coef_sel = COEF_A2;
        cmd_o.opnd_sel = OPND_Y;
      end
      ST_OUT: begin
        cmd_o.commit = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/biquad_iir_filter_core.sv */
// second-order iir section with a single shared coefficient multiplier
//
// input channel: in_valid_i / in_ready_o with sample_in_i and clear_history_i;
//   clear_history_i zeroes all stored history before the sample is filtered
// output channel: out_valid_o / out_ready_i with sample_out_o and saturated_o
// config port: cfg_we_i writes cfg_data_i into the register at cfg_index_i
//   (b0, b1, b2, a1, a2, form select); only write while the block is idle
//
// one transaction is worked on at a time. direct form 1 runs five multiply
// steps and a drain step before the result goes to the output register; a
// new input is taken only once the block is back in idle. transposed form 2
// computes the output first and then the two accumulators, with a wait state
// after the first, third and fifth multiply steps. the shared multiplier and
// the product register ahead of the accumulator set this sequence of steps.
//
// reset loads the default coefficients (b0 = 1.0, others zero), selects
// direct form 1 and zeroes the history. a result waits in the output
// register while the receiver stalls; the next input is still taken and
// filtered, and its result is held back until the output register frees up.
module biquad_iir_filter_core #(
  parameter int SAMPLE_WIDTH   = biq_pkg::SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [biq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_FRAC_BITS+2:0]     cfg_data_i,
  // input samples
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                          clear_history_i,
  // filtered samples
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                          saturated_o
);
  import biq_pkg::*;

  // command and status between sequencer and datapath
  biq_cmd_t    cmd;
  biq_status_t status;

  // sequencer: walks the multiply steps of the selected form
  biq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: coefficients, history, multiplier, accumulator, output register
  biq_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_in_i     (sample_in_i),
    .clear_history_i (clear_history_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .sample_out_o    (sample_out_o),
    .saturated_o     (saturated_o)
  );

endmodule

/* sv/biq_checker.sv */
module biq_checker #(
  parameter int SAMPLE_WIDTH = biq_pkg::SAMPLE_WIDTH
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  input logic                           saturated_o
);

  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // one transaction at a time: no input is taken right after another
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a sample is being filtered");

  // a result never appears right after an input transaction
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too soon after input");

  // a fresh result leaves the block idle and ready for the next sample
  a_result_then_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("new result without returning to idle");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(sample_out_o) && $stable(saturated_o))
    else $error("stalled result changed");

  // the clip flag only comes with a full-scale output
  a_sat_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> sample_out_o == OUT_MAX || sample_out_o == OUT_MIN)
    else $error("clip flag set on an in-range output");

endmodule

bind biquad_iir_filter_core biq_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_biq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o),
  .saturated_o  (saturated_o)
);
